>>> rtl/stfd_pkg.sv
// Shared definitions for the sorted key table: codes, field widths and the
// control word that the sequencer broadcasts along the row of cells.
// No dependencies.
package stfd_pkg;

   // default table depth
   localparam int CAPACITY_DEF = 128;

   // field widths
   localparam int KEY_W    = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 8;

   // encoder grouping: one-hot bits reduced per group of this size
   localparam int GROUP_N = 16;
   localparam int GROUP_W = 4;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // control word broadcast to every cell
   typedef struct packed {
      logic                    cmp_en;   // compare key against held entry
      logic                    strict;   // count entries <= key (insert)
      logic                    ins_sel;  // boundary alone marks the position
      logic                    ins_go;   // open a slot at the boundary
      logic                    del_go;   // close the slot at the boundary
      logic signed [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage

>>> rtl/stfd_cell.sv
// One slot of the sorted key table: holds an entry, compares it with the
// broadcast key and shifts with its neighbours on insert or delete.
// Depends on stfd_pkg.
module stfd_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stfd_pkg::cell_ctl_type             ctl,
   input  logic [CNT_W-1:0]                   used,
   input  logic signed [stfd_pkg::KEY_W-1:0]  left_entry,
   input  logic                               left_flag,
   input  logic signed [stfd_pkg::KEY_W-1:0]  right_entry,
   output logic signed [stfd_pkg::KEY_W-1:0]  entry,
   output logic                               flag,
   output logic                               sel
);

   logic signed [stfd_pkg::KEY_W-1:0] entry_ff, entry_in;
   logic                              flag_ff, flag_in;
   logic                              eq_ff, eq_in;
   logic                              valid;
   logic                              boundary;

   assign valid    = (CNT_W'(IDX) < used);
   assign boundary = left_flag & ~flag_ff;

   // compare against the key; flags hold until the next compare
   always_comb begin
      flag_in = flag_ff;
      eq_in   = eq_ff;
      if (ctl.cmp_en) begin
         flag_in = valid & (ctl.strict ? (entry_ff <= ctl.key) : (entry_ff < ctl.key));
         eq_in   = valid & (entry_ff == ctl.key);
      end
   end

   // shift up past the boundary on insert, down from it on delete
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_go && !flag_ff) begin
         entry_in = boundary ? ctl.key : left_entry;
      end else if (ctl.del_go && !flag_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
         eq_ff   <= 1'b0;
      end else begin
         flag_ff <= flag_in;
         eq_ff   <= eq_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign flag  = flag_ff;
   assign sel   = boundary & (ctl.ins_sel | eq_ff);

endmodule

>>> rtl/stfd_encode.sv
// Two-stage registered encoder: turns the one-hot position word from the
// cells into a hit bit and a binary index. Depends on stfd_pkg.
module stfd_encode #(
   parameter int N = stfd_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [N-1:0]                         sel,
   output logic                                 hit,
   output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);

   localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
   localparam int GN    = stfd_pkg::GROUP_N;
   localparam int NG    = (N + GN - 1) / GN;
   localparam int PAD_W = NG * GN;

   logic [PAD_W-1:0]             sel_pad;
   logic [NG-1:0]                grp_hit_ff, grp_hit_in;
   logic [stfd_pkg::GROUP_W-1:0] grp_loc_ff [NG];
   logic [stfd_pkg::GROUP_W-1:0] grp_loc_in [NG];
   logic                         hit_ff, hit_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;

   assign sel_pad = PAD_W'(sel);

   // first stage: hit and local index per group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_hit_in[g] = |sel_pad[g*GN +: GN];
         grp_loc_in[g] = '0;
         for (int j = 0; j < GN; j++) begin
            if (sel_pad[g*GN + j]) begin
               grp_loc_in[g] = grp_loc_in[g] | stfd_pkg::GROUP_W'(j);
            end
         end
      end
   end

   // second stage: combine group base and local index
   always_comb begin
      hit_in = |grp_hit_ff;
      idx_in = '0;
      for (int g = 0; g < NG; g++) begin
         if (grp_hit_ff[g]) begin
            idx_in = idx_in | IDX_W'(g * GN) | IDX_W'(grp_loc_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_hit_ff <= '0;
         hit_ff     <= 1'b0;
      end else begin
         grp_hit_ff <= grp_hit_in;
         hit_ff     <= hit_in;
      end
      for (int g = 0; g < NG; g++) begin
         grp_loc_ff[g] <= grp_loc_in[g];
      end
      idx_ff <= idx_in;
   end

   assign hit = hit_ff;
   assign idx = idx_ff;

endmodule

>>> rtl/sorted_table_insert_find_delete.sv
// Sorted key table with insert, find and delete on a row of compare cells.
// Path from request accept to result valid: cell compare, two encoder stages,
// table update; a new request is taken only after the last one's update.
// A waiting result does not block the next request until its update cycle.
// Reset clears the fill count and control state; entries are left as they
// are and need no clearing pass.
module sorted_table_insert_find_delete #(
   parameter int CAPACITY = stfd_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [stfd_pkg::REQ_W-1:0]          req_type,
   input  logic signed [stfd_pkg::KEY_W-1:0]   req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [stfd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [stfd_pkg::POS_W-1:0]          rsp_position,
   output logic [stfd_pkg::POS_W-1:0]          rsp_fill_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ENC1  = 2'd1;
   localparam logic [1:0] S_ENC2  = 2'd2;
   localparam logic [1:0] S_APPLY = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [CNT_W-1:0]                  used_ff, used_in;
   logic [stfd_pkg::REQ_W-1:0]        op_ff;
   logic signed [stfd_pkg::KEY_W-1:0] key_ff;
   logic                              rsp_valid_ff;
   logic [stfd_pkg::STATUS_W-1:0]     rsp_status_ff, status_in;
   logic [stfd_pkg::POS_W-1:0]        rsp_position_ff, rsp_fill_count_ff;
   logic [CNT_W-1:0]                  pos_in;
   logic                              accept;
   logic                              out_free;
   logic                              apply_fire;
   logic                              ins_go, del_go;
   stfd_pkg::cell_ctl_type            ctl;

   logic signed [stfd_pkg::KEY_W-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0]               cell_flag;
   logic [CAPACITY-1:0]               cell_sel;
   logic                              enc_hit;
   logic [IDX_W-1:0]                  enc_idx;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid & req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign apply_fire = (state_ff == S_APPLY) & out_free;

   // broadcast word: compare on accept, shift on update
   always_comb begin
      ctl.cmp_en  = accept;
      ctl.strict  = (req_type == stfd_pkg::REQ_INSERT);
      ctl.ins_sel = (op_ff == stfd_pkg::REQ_INSERT);
      ctl.ins_go  = ins_go;
      ctl.del_go  = del_go;
      ctl.key     = (state_ff == S_IDLE) ? req_key : key_ff;
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [stfd_pkg::KEY_W-1:0] left_entry, right_entry;
      logic                              left_flag;

      if (i == 0) begin : g_first
         assign left_entry = cell_entry[i];
         assign left_flag  = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_flag  = cell_flag[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      stfd_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .used        (used_ff),
         .left_entry  (left_entry),
         .left_flag   (left_flag),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .flag        (cell_flag[i]),
         .sel         (cell_sel[i])
      );
   end

   stfd_encode #(
      .N (CAPACITY)
   ) u_encode (
      .clock (clock),
      .reset (reset),
      .sel   (cell_sel),
      .hit   (enc_hit),
      .idx   (enc_idx)
   );

   // decide the result and the table update
   always_comb begin
      status_in = stfd_pkg::STATUS_NOT_FOUND;
      pos_in    = CNT_W'(CAPACITY);
      used_in   = used_ff;
      ins_go    = 1'b0;
      del_go    = 1'b0;
      case (op_ff)
         stfd_pkg::REQ_INSERT: begin
            if (used_ff == CNT_W'(CAPACITY)) begin
               status_in = stfd_pkg::STATUS_FULL;
            end else begin
               status_in = stfd_pkg::STATUS_OK;
               pos_in    = CNT_W'(enc_idx);
               used_in   = used_ff + CNT_W'(1);
               ins_go    = apply_fire;
            end
         end
         stfd_pkg::REQ_FIND: begin
            if (enc_hit) begin
               status_in = stfd_pkg::STATUS_OK;
               pos_in    = CNT_W'(enc_idx);
            end
         end
         stfd_pkg::REQ_DELETE: begin
            if (enc_hit) begin
               status_in = stfd_pkg::STATUS_OK;
               pos_in    = CNT_W'(enc_idx);
               used_in   = used_ff - CNT_W'(1);
               del_go    = apply_fire;
            end
         end
         default: begin
            status_in = stfd_pkg::STATUS_NOT_FOUND;
         end
      endcase
   end

   // advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_ENC1;
         S_ENC1:  state_in = S_ENC2;
         S_ENC2:  state_in = S_APPLY;
         S_APPLY: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (apply_fire) begin
            used_ff      <= used_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request and the result word
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_type;
         key_ff <= req_key;
      end
      if (apply_fire) begin
         rsp_status_ff     <= status_in;
         rsp_position_ff   <= stfd_pkg::POS_W'(pos_in);
         rsp_fill_count_ff <= stfd_pkg::POS_W'(used_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_fill_count = rsp_fill_count_ff;

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_sorted_boundary: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENC1) |-> $onehot0(cell_sel))
      else $error("more than one boundary in the table");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && op_ff == stfd_pkg::REQ_INSERT
       && used_ff != CNT_W'(CAPACITY)) |-> enc_hit)
      else $error("insert found no slot in a table with room");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_APPLY) |=> $stable(used_ff))
      else $error("fill count moved outside the update cycle");
`endif

endmodule

>>> sim/tb_top.sv
// Testbench for the sorted key table: drives insert, find and delete words,
// predicts every reply with its own copy of the table and checks each field.
// Depends on rtl/stfd_pkg.sv and rtl/sorted_table_insert_find_delete.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = stfd_pkg::CAPACITY_DEF;
   localparam logic [stfd_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;   // unused request code
   localparam logic signed [stfd_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [stfd_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [stfd_pkg::STATUS_W-1:0] status;
      logic [stfd_pkg::POS_W-1:0]    position;
      logic [stfd_pkg::POS_W-1:0]    fill;
   } table_reply_type;

   // Mirror of the key table; works out the reply to every accepted word
   class table_scoreboard;
      logic signed [stfd_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
      int                                count;
      table_reply_type                   replies_due [$];
      int                                failures;
      int                                n_insert, n_find, n_delete, n_spare;
      int                                n_full, n_miss, peak_fill, n_checked;

      function void note_request(logic [stfd_pkg::REQ_W-1:0] kind,
                                 logic signed [stfd_pkg::KEY_W-1:0] key);
         table_reply_type r;
         int              slot;
         int              k;
         r.status   = stfd_pkg::STATUS_NOT_FOUND;
         r.position = stfd_pkg::POS_W'(TABLE_DEPTH);
         case (kind)
            stfd_pkg::REQ_INSERT: begin
               n_insert++;
               if (count >= TABLE_DEPTH) begin
                  r.status = stfd_pkg::STATUS_FULL;
                  n_full++;
               end else begin
                  // insert after every entry <= key, shift the rest up
                  slot = 0;
                  while (slot < count && keys[slot] <= key) slot++;
                  for (k = count; k > slot; k--) keys[k] = keys[k-1];
                  keys[slot] = key;
                  count++;
                  r.status   = stfd_pkg::STATUS_OK;
                  r.position = stfd_pkg::POS_W'(slot);
               end
            end
            stfd_pkg::REQ_FIND, stfd_pkg::REQ_DELETE: begin
               if (kind == stfd_pkg::REQ_FIND) n_find++;
               else n_delete++;
               // lowest slot holding an entry >= key
               slot = 0;
               while (slot < count && keys[slot] < key) slot++;
               if (slot < count && keys[slot] == key) begin
                  r.status   = stfd_pkg::STATUS_OK;
                  r.position = stfd_pkg::POS_W'(slot);
                  if (kind == stfd_pkg::REQ_DELETE) begin
                     for (k = slot; k + 1 < count; k++) keys[k] = keys[k+1];
                     count--;
                  end
               end else begin
                  n_miss++;
               end
            end
            default: n_spare++;
         endcase
         if (count > peak_fill) peak_fill = count;
         r.fill = stfd_pkg::POS_W'(count);
         replies_due.push_back(r);
      endfunction

      function void check_word(table_reply_type got);
         table_reply_type want;
         if (replies_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: reply with none pending: status %0d pos %0d fill %0d",
                        got.status, got.position, got.fill);
         end else begin
            want = replies_due.pop_front();
            n_checked++;
            if (want.status !== got.status || want.position !== got.position ||
                want.fill !== got.fill) begin
               failures++;
               if (failures <= 10)
                  $display({"ERROR: reply %0d: expected status %0d pos %0d fill %0d,",
                            " got %0d %0d %0d"},
                           n_checked, want.status, want.position, want.fill,
                           got.status, got.position, got.fill);
            end
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [stfd_pkg::REQ_W-1:0]        req_type;
   logic signed [stfd_pkg::KEY_W-1:0] req_key;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [stfd_pkg::STATUS_W-1:0]     rsp_status;
   logic [stfd_pkg::POS_W-1:0]        rsp_position;
   logic [stfd_pkg::POS_W-1:0]        rsp_fill_count;

   table_scoreboard board;
   int              words_sent;

   sorted_table_insert_find_delete dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fill_count (rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("timeout: %0d words sent, %0d replies pending",
               words_sent, board.replies_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one word and hold it until the block takes it
   task automatic send_word(input logic [stfd_pkg::REQ_W-1:0] kind,
                            input logic signed [stfd_pkg::KEY_W-1:0] key);
      req_valid <= 1'b1;
      req_type  <= kind;
      req_key   <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(kind, key);
      words_sent++;
   endtask

   // Receiver: changing stall pattern, plus one long hold-off to back up the block
   int rx_tick;
   int rx_mode;
   int hold_left;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && words_sent >= 90) begin
            hold_left = 250;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (rx_tick % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         rx_tick++;
      end
   end

   // Check every reply the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_word('{status: rsp_status, position: rsp_position,
                            fill: rsp_fill_count});
   end

   initial begin
      int                                i;
      int                                sel;
      int                                hit_pct;
      int                                burst_left;
      int                                gap;
      logic [stfd_pkg::REQ_W-1:0]        kind;
      logic signed [stfd_pkg::KEY_W-1:0] key;

      board      = new;
      words_sent = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_type   = stfd_pkg::REQ_INSERT;
      req_key    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, spare code, extremes, duplicates, misses
      send_word(stfd_pkg::REQ_FIND,   32'sd0);
      send_word(stfd_pkg::REQ_DELETE, 32'sd5);
      send_word(REQ_SPARE,            32'sd0);
      send_word(stfd_pkg::REQ_INSERT, KEY_MAX);
      send_word(stfd_pkg::REQ_INSERT, KEY_MIN);
      send_word(stfd_pkg::REQ_INSERT, 32'sd0);
      send_word(stfd_pkg::REQ_INSERT, 32'sd0);
      send_word(stfd_pkg::REQ_INSERT, 32'sd0);
      send_word(stfd_pkg::REQ_INSERT, -32'sd1);
      send_word(stfd_pkg::REQ_INSERT, 32'sd1);
      send_word(stfd_pkg::REQ_FIND,   32'sd0);
      send_word(stfd_pkg::REQ_FIND,   KEY_MIN);
      send_word(stfd_pkg::REQ_FIND,   KEY_MAX);
      send_word(stfd_pkg::REQ_FIND,   32'sd7);
      send_word(stfd_pkg::REQ_FIND,   -32'sd1);
      send_word(stfd_pkg::REQ_DELETE, 32'sd0);
      send_word(stfd_pkg::REQ_FIND,   32'sd0);
      send_word(stfd_pkg::REQ_DELETE, KEY_MAX);
      send_word(stfd_pkg::REQ_DELETE, KEY_MIN);
      send_word(stfd_pkg::REQ_DELETE, 32'sd99);
      send_word(REQ_SPARE,            KEY_MAX);
      send_word(stfd_pkg::REQ_FIND,   KEY_MIN + 32'sd1);

      // Random: fill to the brim, drain to empty, then a mixed stretch
      burst_left = $urandom_range(1, 12);
      for (i = 0; i < 650; i++) begin
         sel = $urandom_range(0, 99);
         if (i < 200) begin
            kind    = sel < 78 ? stfd_pkg::REQ_INSERT : sel < 88 ? stfd_pkg::REQ_FIND :
                      sel < 96 ? stfd_pkg::REQ_DELETE : REQ_SPARE;
            hit_pct = 50;
         end else if (i < 420) begin
            kind    = sel < 10 ? stfd_pkg::REQ_INSERT : sel < 25 ? stfd_pkg::REQ_FIND :
                      sel < 97 ? stfd_pkg::REQ_DELETE : REQ_SPARE;
            hit_pct = 85;
         end else begin
            kind    = sel < 40 ? stfd_pkg::REQ_INSERT : sel < 70 ? stfd_pkg::REQ_FIND :
                      sel < 97 ? stfd_pkg::REQ_DELETE : REQ_SPARE;
            hit_pct = 55;
         end

         // key: a held one, a small value for duplicates, full range or extremes
         sel = $urandom_range(0, 99);
         if (board.count > 0 && kind != stfd_pkg::REQ_INSERT && sel < hit_pct) begin
            key = board.keys[$urandom_range(0, board.count - 1)];
         end else begin
            sel = $urandom_range(0, 9);
            if (sel < 6)       key = $signed($urandom_range(0, 40)) - 32'sd20;
            else if (sel < 8)  key = $urandom;
            else if (sel == 8) key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            else               key = $urandom_range(0, 1) ? KEY_MIN + 32'sd1 : KEY_MAX - 32'sd1;
         end

         send_word(kind, key);

         // bursts with gaps; now and then a long burst with no gap at all
         burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding replies, then wait for strays
      while (board.replies_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d words: %0d insert, %0d find, %0d delete, %0d spare code",
               words_sent, board.n_insert, board.n_find, board.n_delete, board.n_spare);
      $display("table peaked at %0d of %0d; %0d full refusals, %0d misses, %0d mismatches",
               board.peak_fill, TABLE_DEPTH, board.n_full, board.n_miss, board.failures);
      if (board.failures == 0 && board.replies_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
